// ===== src/mrsq_pkg.sv =====
`default_nettype none

package mrsq_pkg;

	// field widths
	localparam int PIX_W = 8;
	localparam int OP_W  = 2;
	localparam int NSH_W = 9;

	// divider operand widths: scaled edge offsets stay below 2^17, divisors reach 512
	localparam int DVD_W = 17;
	localparam int DVS_W = 10;
	localparam int CNT_W = $clog2(DVD_W);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUANT   = 2'd2;

	localparam logic [NSH_W-1:0] NSH_RESET = 9'd2;
	localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;

	// quantize job with the statistics seen when it was accepted
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
	} qent_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_EDGE,
		BK_DIV_BIN,
		BK_MUL,
		BK_MID,
		BK_DIV_MID,
		BK_OUT
	} bk_state_t;

endpackage

`default_nettype wire

// ===== src/mrsq_front.sv =====
`default_nettype none

module mrsq_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [mrsq_pkg::OP_W-1:0]  s_tuser,  // [1:0] operation
	input  wire  [mrsq_pkg::PIX_W-1:0] s_tdata,  // [7:0] pixel
	input  wire                        cfg_wen,
	input  wire  [mrsq_pkg::NSH_W-1:0] cfg_wdata,
	input  wire                        q_full,
	output logic                       push,
	output mrsq_pkg::qent_t            push_data,
	output logic [mrsq_pkg::NSH_W-1:0] num_shades
);

	logic [mrsq_pkg::PIX_W-1:0] lo_q;
	logic [mrsq_pkg::PIX_W-1:0] hi_q;
	logic [mrsq_pkg::NSH_W-1:0] nsh_q;
	logic                       beat;

	assign s_tready   = !q_full;
	assign beat       = s_tvalid && s_tready;
	assign num_shades = nsh_q;

	// quantize beats go to the back end with a snapshot of the range
	always_comb begin
		push            = beat && (s_tuser == mrsq_pkg::OP_QUANT);
		push_data.pixel = s_tdata;
		push_data.lo    = lo_q;
		push_data.hi    = hi_q;
	end

	// running min and max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= mrsq_pkg::PIX_MAX;
			hi_q <= '0;
		end else if (beat) begin
			case (s_tuser)
				mrsq_pkg::OP_CLEAR: begin
					lo_q <= mrsq_pkg::PIX_MAX;
					hi_q <= '0;
				end
				mrsq_pkg::OP_MEASURE: begin
					if (s_tdata < lo_q) lo_q <= s_tdata;
					if (s_tdata > hi_q) hi_q <= s_tdata;
				end
				default: begin
				end
			endcase
		end
	end

	// shade count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsh_q <= mrsq_pkg::NSH_RESET;
		end else if (cfg_wen) begin
			nsh_q <= cfg_wdata;
		end
	end

endmodule

`default_nettype wire

// ===== src/mrsq_queue.sv =====
`default_nettype none

module mrsq_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  mrsq_pkg::qent_t push_data,
	input  wire             pop,
	output mrsq_pkg::qent_t head,
	output logic            full,
	output logic            empty
);

	mrsq_pkg::qent_t                 mem [mrsq_pkg::QDEPTH];
	logic [mrsq_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mrsq_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mrsq_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = (cnt_q == mrsq_pkg::QCNT_W'(mrsq_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/mrsq_div.sv =====
`default_nettype none

module mrsq_div (
	input  wire                clk,
	input  wire                arst_n,
	input  mrsq_pkg::div_req_t req,
	output mrsq_pkg::div_rsp_t rsp
);

	logic [mrsq_pkg::DVD_W-1:0] quo_q;
	logic [mrsq_pkg::DVS_W-1:0] rem_q;
	logic [mrsq_pkg::DVS_W-1:0] dvs_q;
	logic [mrsq_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [mrsq_pkg::DVS_W:0]   shifted;
	logic                       ge;
	logic [mrsq_pkg::DVS_W-1:0] rem_nxt;

	// one restoring step per cycle
	always_comb begin
		shifted = {rem_q, quo_q[mrsq_pkg::DVD_W-1]};
		ge      = (shifted >= {1'b0, dvs_q});
		if (ge) begin
			rem_nxt = mrsq_pkg::DVS_W'(shifted - {1'b0, dvs_q});
		end else begin
			rem_nxt = shifted[mrsq_pkg::DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mrsq_pkg::CNT_W'(mrsq_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient and partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mrsq_pkg::DVD_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/mrsq_back.sv =====
`default_nettype none

module mrsq_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  mrsq_pkg::qent_t            head,
	input  wire                        q_empty,
	output logic                       pop,
	input  wire  [mrsq_pkg::NSH_W-1:0] num_shades,
	output mrsq_pkg::div_req_t         div_req,
	input  mrsq_pkg::div_rsp_t         div_rsp,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [mrsq_pkg::PIX_W-1:0] m_tdata
);

	mrsq_pkg::bk_state_t state_q;
	mrsq_pkg::bk_state_t state_nxt;

	logic [mrsq_pkg::PIX_W-1:0] pixel_q;
	logic [mrsq_pkg::PIX_W-1:0] lo_q;
	logic [mrsq_pkg::PIX_W-1:0] hi_q;
	logic [mrsq_pkg::NSH_W-1:0] n_q;
	logic [mrsq_pkg::NSH_W-1:0] r_q;
	logic [mrsq_pkg::DVD_W-1:0] nlo_q;
	logic [mrsq_pkg::DVD_W-1:0] tgt_q;
	logic [mrsq_pkg::DVD_W-1:0] k_q;
	logic [mrsq_pkg::DVD_W-1:0] prod_q;
	logic [mrsq_pkg::PIX_W-1:0] res_q;
	logic [mrsq_pkg::PIX_W-1:0] shade_q;
	logic                       ovalid_q;

	logic [mrsq_pkg::NSH_W-1:0] n_eff;
	logic signed [9:0]          r_s;
	logic                       bypass;
	logic [mrsq_pkg::DVS_W-1:0] n2;
	logic [mrsq_pkg::DVS_W-1:0] r2;
	logic [17:0]                lim;
	logic [17:0]                tclip;
	logic signed [18:0]         d_s;
	logic                       d_neg;
	logic [17:0]                v;
	logic                       load_out;

	// setup arithmetic
	always_comb begin
		n_eff  = (num_shades == '0) ? mrsq_pkg::NSH_W'(1) : num_shades;
		r_s    = $signed({2'b00, hi_q}) - $signed({2'b00, lo_q}) + 10'sd1;
		bypass = ($signed({1'b0, n_eff}) >= r_s);
		n2     = {n_q, 1'b0};
		r2     = {r_q, 1'b0};
	end

	// first edge above the pixel, offset from the first bin edge
	always_comb begin
		lim   = {n2, 8'b0} - {8'b0, n2};
		tclip = ({1'b0, tgt_q} < lim) ? {1'b0, tgt_q} : (lim - 18'd1);
		d_s   = $signed({1'b0, tclip}) - $signed({2'b00, nlo_q})
		        + $signed({10'b0, n_q});
		d_neg = d_s[18];
		v     = {1'b0, nlo_q} + {1'b0, prod_q} - {9'b0, n_q} - {9'b0, r_q};
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mrsq_pkg::BK_IDLE:    if (!q_empty) state_nxt = mrsq_pkg::BK_SETUP;
			mrsq_pkg::BK_SETUP:   state_nxt = bypass ? mrsq_pkg::BK_OUT : mrsq_pkg::BK_EDGE;
			mrsq_pkg::BK_EDGE:    state_nxt = d_neg ? mrsq_pkg::BK_MUL : mrsq_pkg::BK_DIV_BIN;
			mrsq_pkg::BK_DIV_BIN: if (div_rsp.done) state_nxt = mrsq_pkg::BK_MUL;
			mrsq_pkg::BK_MUL:     state_nxt = mrsq_pkg::BK_MID;
			mrsq_pkg::BK_MID:     state_nxt = mrsq_pkg::BK_DIV_MID;
			mrsq_pkg::BK_DIV_MID: if (div_rsp.done) state_nxt = mrsq_pkg::BK_OUT;
			mrsq_pkg::BK_OUT:     if (!ovalid_q || m_tready) state_nxt = mrsq_pkg::BK_IDLE;
			default:              state_nxt = mrsq_pkg::BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop              = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = d_s[mrsq_pkg::DVD_W-1:0];
		div_req.divisor  = r2;
		case (state_q)
			mrsq_pkg::BK_IDLE: pop = !q_empty;
			mrsq_pkg::BK_EDGE: div_req.start = !d_neg;
			mrsq_pkg::BK_MID: begin
				div_req.start    = 1'b1;
				div_req.dividend = v[mrsq_pkg::DVD_W-1:0];
				div_req.divisor  = n2;
			end
			mrsq_pkg::BK_OUT: load_out = !ovalid_q || m_tready;
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mrsq_pkg::BK_IDLE;
		else         state_q <= state_nxt;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			mrsq_pkg::BK_IDLE: begin
				pixel_q <= head.pixel;
				lo_q    <= head.lo;
				hi_q    <= head.hi;
			end
			mrsq_pkg::BK_SETUP: begin
				res_q <= pixel_q;
				n_q   <= n_eff;
				r_q   <= r_s[mrsq_pkg::NSH_W-1:0];
				nlo_q <= mrsq_pkg::DVD_W'({n_eff, 1'b0} * lo_q);
				tgt_q <= mrsq_pkg::DVD_W'({n_eff, 1'b0} * pixel_q);
			end
			mrsq_pkg::BK_EDGE:    k_q <= mrsq_pkg::DVD_W'(1);
			mrsq_pkg::BK_DIV_BIN: k_q <= div_rsp.quo + 1'b1;
			mrsq_pkg::BK_MUL:     prod_q <= mrsq_pkg::DVD_W'(r2 * k_q);
			mrsq_pkg::BK_DIV_MID: begin
				if (div_rsp.quo > mrsq_pkg::DVD_W'(mrsq_pkg::PIX_MAX)) res_q <= mrsq_pkg::PIX_MAX;
				else res_q <= div_rsp.quo[mrsq_pkg::PIX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) shade_q <= res_q;
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = shade_q;

endmodule

`default_nettype wire

// ===== src/minmax_range_shade_quantizer_unit.sv =====
// Grey pixel quantizer over a measured luminance range. Clear and measure beats
// are taken by the front end and update the running min and max; quantize
// beats enter a two-entry queue together with the range in force when they
// arrived, so later measure beats do not disturb them. The back end turns each
// queued pixel into the midpoint of one of num_shades uniform bins, using exact
// integer math scaled by twice the shade count. A quantize beat makes up to two
// passes through the shared 17-step serial divider (bin index, then midpoint);
// a pixel that passes unchanged skips the divider. The result waits in an
// output register, so the front keeps accepting while the queue has room. The
// user must write num_shades only while the block is idle; the block itself
// does not enforce this.
`default_nettype none

module minmax_range_shade_quantizer_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [mrsq_pkg::OP_W-1:0]  s_tuser,   // [1:0] operation
	input  wire  [mrsq_pkg::PIX_W-1:0] s_tdata,   // [7:0] pixel
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [mrsq_pkg::PIX_W-1:0] m_tdata,   // [7:0] shade
	input  wire                        cfg_wen,
	input  wire  [mrsq_pkg::NSH_W-1:0] cfg_wdata  // num_shades
);

	logic                       push;
	mrsq_pkg::qent_t            push_data;
	logic                       pop;
	mrsq_pkg::qent_t            head;
	logic                       q_full;
	logic                       q_empty;
	logic [mrsq_pkg::NSH_W-1:0] num_shades;
	mrsq_pkg::div_req_t         div_req;
	mrsq_pkg::div_rsp_t         div_rsp;

	mrsq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data),
		.num_shades (num_shades)
	);

	mrsq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	mrsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mrsq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.num_shades (num_shades),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

`default_nettype wire

// ===== src/mrsq_checker.sv =====
`default_nettype none

module mrsq_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire  [mrsq_pkg::OP_W-1:0]  s_tuser,
	input wire                        m_tvalid,
	input wire                        m_tready
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// only a queued quantize beat can fill the queue
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tuser == mrsq_pkg::OP_QUANT))
		else $error("input stalled without a quantize beat");

	// queue starts empty after reset
	a_ready_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> s_tready)
		else $error("input not ready after reset");

endmodule

bind minmax_range_shade_quantizer_unit mrsq_checker u_mrsq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire

// ===== bench/minmax_range_shade_quantizer_unit_tb.sv =====
`timescale 1ns / 100ps

module minmax_range_shade_quantizer_unit_tb;

	// code that the block takes and drops
	localparam logic [mrsq_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [mrsq_pkg::OP_W-1:0]  op;
		logic [mrsq_pkg::PIX_W-1:0] pixel;
	} pix_beat_t;

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	wire                          s_tready;
	logic [mrsq_pkg::OP_W-1:0]    s_tuser   = mrsq_pkg::OP_CLEAR;
	logic [mrsq_pkg::PIX_W-1:0]   s_tdata   = '0;
	wire                          m_tvalid;
	logic                         m_tready  = 1'b0;
	wire  [mrsq_pkg::PIX_W-1:0]   m_tdata;
	logic                         cfg_wen   = 1'b0;
	logic [mrsq_pkg::NSH_W-1:0]   cfg_wdata = '0;

	// pending input beats and expected shades
	pix_beat_t                    beat_q[$];
	logic [mrsq_pkg::PIX_W-1:0]   shade_q[$];

	// model copy of the statistics and of num_shades
	logic [mrsq_pkg::PIX_W-1:0]   seen_lo    = mrsq_pkg::PIX_MAX;
	logic [mrsq_pkg::PIX_W-1:0]   seen_hi    = '0;
	logic [mrsq_pkg::NSH_W-1:0]   shades_cfg = mrsq_pkg::NSH_RESET;

	int                           idle_pct  = 0;
	int                           send_gap  = 0;
	int                           sink_gap  = 0;
	int                           errors    = 0;
	pix_beat_t                    nxt_beat;
	logic [mrsq_pkg::PIX_W-1:0]   want;

	minmax_range_shade_quantizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// bin midpoint for one pixel, all terms scaled by twice the shade count
	function automatic logic [mrsq_pkg::PIX_W-1:0] shade_of(int pix, int lo, int hi, int nsh);
		int n, r, n2, edge_v, lim, tgt, v;
		n = (nsh == 0) ? 1 : nsh;
		r = hi - lo + 1;
		if (n >= r)
			return pix[mrsq_pkg::PIX_W-1:0];
		n2     = 2 * n;
		edge_v = n2 * lo - n + 2 * r;
		lim    = 255 * n2;
		tgt    = n2 * pix;
		while (edge_v < lim && tgt >= edge_v)
			edge_v += 2 * r;
		v = edge_v - r;
		if (v < 0)
			v = 0;
		v = v / n2;
		if (v > 255)
			v = 255;
		return v[mrsq_pkg::PIX_W-1:0];
	endfunction

	// source side: one beat per free slot, random bursts of idle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (beat_q.size() != 0) begin
				nxt_beat = beat_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nxt_beat.op;
				s_tdata  <= nxt_beat.pixel;
				if ($urandom_range(0, 99) < idle_pct)
					send_gap = $urandom_range(1, 5);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap = sink_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < idle_pct)
				sink_gap = $urandom_range(1, 5);
		end
	end

	// track accepted beats and check shades in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					mrsq_pkg::OP_CLEAR: begin
						seen_lo = mrsq_pkg::PIX_MAX;
						seen_hi = '0;
					end
					mrsq_pkg::OP_MEASURE: begin
						if (s_tdata < seen_lo)
							seen_lo = s_tdata;
						if (s_tdata > seen_hi)
							seen_hi = s_tdata;
					end
					mrsq_pkg::OP_QUANT: begin
						shade_q.push_back(shade_of(int'(s_tdata), int'(seen_lo),
							int'(seen_hi), int'(shades_cfg)));
					end
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (shade_q.size() == 0) begin
					$error("shade: expected none, actual %0d", m_tdata);
					errors = errors + 1;
				end else begin
					want = shade_q.pop_front();
					if (m_tdata !== want) begin
						$error("shade: expected %0d, actual %0d", want, m_tdata);
						errors = errors + 1;
					end
				end
			end
		end
	end

	task automatic add_beat(logic [mrsq_pkg::OP_W-1:0] op, logic [mrsq_pkg::PIX_W-1:0] pixel);
		pix_beat_t b;
		b.op    = op;
		b.pixel = pixel;
		beat_q.push_back(b);
	endtask

	// wait until every beat is taken and every shade is back
	task automatic drain();
		do
			@(negedge clk);
		while (beat_q.size() != 0 || s_tvalid || shade_q.size() != 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_shades(logic [mrsq_pkg::NSH_W-1:0] v);
		@(posedge clk);
		cfg_wen    <= 1'b1;
		cfg_wdata  <= v;
		shades_cfg = v;
		@(posedge clk);
		cfg_wen    <= 1'b0;
	endtask

	// one frame: clear, measure pass over a random range, quantize pass with some noise
	task automatic add_frame();
		int lo_b, hi_b, n_meas, n_quant;
		lo_b = $urandom_range(0, 255);
		hi_b = $urandom_range(lo_b, 255);
		if ($urandom_range(0, 3) == 0) begin
			lo_b = 0;
			hi_b = 255;
		end
		add_beat(mrsq_pkg::OP_CLEAR, mrsq_pkg::PIX_W'($urandom));
		n_meas = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
		repeat (n_meas)
			add_beat(mrsq_pkg::OP_MEASURE, mrsq_pkg::PIX_W'($urandom_range(lo_b, hi_b)));
		n_quant = $urandom_range(1, 12);
		repeat (n_quant) begin
			if ($urandom_range(0, 9) == 0)
				add_beat(mrsq_pkg::OP_W'($urandom_range(0, 3)), mrsq_pkg::PIX_W'($urandom));
			else if ($urandom_range(0, 3) == 0)
				add_beat(mrsq_pkg::OP_QUANT, mrsq_pkg::PIX_W'($urandom));
			else
				add_beat(mrsq_pkg::OP_QUANT, mrsq_pkg::PIX_W'($urandom_range(lo_b, hi_b)));
		end
	endtask

	initial begin
		int shade_steps[9];
		shade_steps = '{1, 256, 0, 511, 3, 16, 0, 255, 7};
		shade_steps[6] = $urandom_range(2, 64);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset shade count, empty range, ignored code, range edges
		idle_pct = 20;
		add_beat(mrsq_pkg::OP_QUANT, 8'h00);
		add_beat(mrsq_pkg::OP_QUANT, 8'hFF);
		add_beat(OP_SPARE, 8'hAA);
		add_beat(OP_SPARE, 8'h55);
		add_beat(mrsq_pkg::OP_MEASURE, 8'h40);
		add_beat(mrsq_pkg::OP_MEASURE, 8'hC0);
		add_beat(mrsq_pkg::OP_QUANT, 8'h00);
		add_beat(mrsq_pkg::OP_QUANT, 8'h80);
		add_beat(mrsq_pkg::OP_QUANT, 8'hFF);
		add_beat(mrsq_pkg::OP_QUANT, 8'h40);
		add_beat(mrsq_pkg::OP_QUANT, 8'hC0);
		add_beat(mrsq_pkg::OP_CLEAR, 8'h00);
		add_beat(mrsq_pkg::OP_MEASURE, 8'h00);
		add_beat(mrsq_pkg::OP_MEASURE, 8'hFF);
		add_beat(mrsq_pkg::OP_QUANT, 8'h00);
		add_beat(mrsq_pkg::OP_QUANT, 8'h7F);
		add_beat(mrsq_pkg::OP_QUANT, 8'h80);
		add_beat(mrsq_pkg::OP_QUANT, 8'hFF);
		add_beat(mrsq_pkg::OP_CLEAR, 8'hFF);
		add_beat(mrsq_pkg::OP_MEASURE, 8'd100);
		add_beat(mrsq_pkg::OP_QUANT, 8'd37);
		drain();

		// random frames under several shade counts, the last one with no stalls
		foreach (shade_steps[i]) begin
			set_shades(mrsq_pkg::NSH_W'(shade_steps[i]));
			if (i == 8)
				idle_pct = 0;
			else
				idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
			repeat (3)
				add_frame();
			drain();
		end

		if (errors == 0)
			$display("minmax_range_shade_quantizer_unit_tb OK");
		else
			$display("minmax_range_shade_quantizer_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("minmax_range_shade_quantizer_unit_tb NOT OK");
		$finish;
	end

endmodule
